>>> rtl/core/bbci_pkg.sv
// ----------------------------------------------------------------------------
// bbci_pkg
// Shared types, codes and constants of the black-body color lookup block.
// ----------------------------------------------------------------------------
package bbci_pkg;

   localparam int DEFAULT_TABLE_ENTRIES = 64;

   localparam int TEMP_W       = 20;
   localparam int SCALE_W      = 32;
   localparam int RAW_W        = 24;
   localparam int ENTRY_IDX_W  = 6;
   localparam int CHAN_W       = 2;
   localparam int WORD_W       = 18;
   localparam int COLOR_W      = 32;
   localparam int FRAC_W       = 17;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int NUM_CHANNELS = 3;

   // Cycles from an accepted request to the edge that takes its result.
   localparam int PIPE_LATENCY = 7;

   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

   localparam logic KIND_EVAL  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   localparam logic [CHAN_W-1:0] CH_RED   = 2'd0;
   localparam logic [CHAN_W-1:0] CH_GREEN = 2'd1;
   localparam logic [CHAN_W-1:0] CH_BLUE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_T_MIN            = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_T_MAX            = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_SCALE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMALIZE_ENABLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_SCALE        = 3'd4;

   localparam logic [TEMP_W-1:0]  T_MIN_RESET       = 20'd16000;
   localparam logic [TEMP_W-1:0]  T_MAX_RESET       = 20'd640000;
   localparam logic [SCALE_W-1:0] INDEX_SCALE_RESET = 32'd433625;
   localparam logic               NORMALIZE_RESET   = 1'b1;
   localparam logic [RAW_W-1:0]   RAW_SCALE_RESET   = 24'd65536;

   typedef struct packed {
      logic                   kind;
      logic [TEMP_W-1:0]      temperature;
      logic [ENTRY_IDX_W-1:0] entry_index;
      logic [CHAN_W-1:0]      channel;
      logic [WORD_W-1:0]      entry_value;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic is_write;
   } pipe_ctl_type;

   typedef struct packed {
      logic [ENTRY_IDX_W-1:0] entry_index;
      logic [CHAN_W-1:0]      channel;
      logic [WORD_W-1:0]      value;
   } table_wr_type;

   // One table entry: word 0 red, word 1 green, word 2 blue.
   typedef logic [NUM_CHANNELS-1:0][WORD_W-1:0] color_words_type;

endpackage

>>> rtl/core/bbci_position.sv
// ----------------------------------------------------------------------------
// bbci_position
// Clamps the temperature, scales its offset to a table position and splits
// the position into an entry index and a Q.16 fraction.
// ----------------------------------------------------------------------------
module bbci_position #(
   parameter int TABLE_ENTRIES = bbci_pkg::DEFAULT_TABLE_ENTRIES,
   localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              kind,
   input  logic [bbci_pkg::TEMP_W-1:0]       temperature,
   input  logic [bbci_pkg::TEMP_W-1:0]       t_min,
   input  logic [bbci_pkg::TEMP_W-1:0]       t_max,
   input  logic [bbci_pkg::SCALE_W-1:0]      index_scale,
   output bbci_pkg::pipe_ctl_type            ctl,
   output logic [IDX_W-1:0]                  index,
   output logic [bbci_pkg::FRAC_W-1:0]       frac
);
   import bbci_pkg::*;

   localparam int POS_W = TEMP_W + SCALE_W;
   localparam logic [TEMP_W-1:0] LAST_BASE = TEMP_W'(TABLE_ENTRIES - 2);

   logic [TEMP_W-1:0] t_clamp;
   logic [TEMP_W-1:0] offset_in;
   logic [TEMP_W-1:0] offset_ff;
   logic [POS_W-1:0]  pos_in;
   logic [POS_W-1:0]  pos_ff;
   logic [TEMP_W-1:0] base_raw;
   logic              capped;
   pipe_ctl_type      ctl1_in;
   pipe_ctl_type      ctl1_ff;
   pipe_ctl_type      ctl2_ff;

   // The low bound is tested first, so an inverted range ends at zero offset.
   always_comb begin
      if (temperature < t_min) begin
         t_clamp = t_min;
      end else if (temperature > t_max) begin
         t_clamp = t_max;
      end else begin
         t_clamp = temperature;
      end
      offset_in = (t_clamp >= t_min) ? (t_clamp - t_min) : '0;
      ctl1_in.valid    = accept;
      ctl1_in.is_write = (kind == KIND_WRITE);
   end

   assign pos_in = POS_W'(offset_ff) * POS_W'(index_scale);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      pos_ff    <= pos_in;
   end

   // A capped index always leaves at least one whole step, so the fraction
   // is limited to one and the result sits on the last entry.
   always_comb begin
      base_raw = pos_ff[POS_W-1:SCALE_W];
      capped   = (base_raw > LAST_BASE);
      index    = capped ? IDX_W'(TABLE_ENTRIES - 2) : base_raw[IDX_W-1:0];
      frac     = capped ? FRAC_ONE : {1'b0, pos_ff[SCALE_W-1:16]};
   end

   assign ctl = ctl2_ff;

endmodule

>>> rtl/core/bbci_table.sv
// ----------------------------------------------------------------------------
// bbci_table
// Color table in two banks, even and odd entries, so that the two adjacent
// entries of one lookup are read in the same cycle, one from each bank.
// ----------------------------------------------------------------------------
module bbci_table #(
   parameter int TABLE_ENTRIES = bbci_pkg::DEFAULT_TABLE_ENTRIES,
   localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  bbci_pkg::table_wr_type      wr,
   input  logic                        rd_en,
   input  logic [IDX_W-1:0]            rd_index,
   output bbci_pkg::color_words_type   lo_words,
   output bbci_pkg::color_words_type   hi_words
);
   import bbci_pkg::*;

   localparam int EVEN_DEPTH = (TABLE_ENTRIES + 1) / 2;
   localparam int ODD_DEPTH  = TABLE_ENTRIES / 2;
   localparam int EA_W       = (EVEN_DEPTH > 1) ? $clog2(EVEN_DEPTH) : 1;
   localparam int OA_W       = (ODD_DEPTH > 1) ? $clog2(ODD_DEPTH) : 1;

   color_words_type even_mem [EVEN_DEPTH];
   color_words_type odd_mem  [ODD_DEPTH];

   color_words_type even_rd_ff;
   color_words_type odd_rd_ff;
   logic            odd_first_ff;

   logic            entry_ok;
   logic [EA_W-1:0] wr_even_row;
   logic [OA_W-1:0] wr_odd_row;
   logic [EA_W-1:0] rd_even_row;
   logic [OA_W-1:0] rd_odd_row;

   assign entry_ok    = (int'(wr.entry_index) < TABLE_ENTRIES);
   assign wr_even_row = EA_W'(wr.entry_index[ENTRY_IDX_W-1:1]);
   assign wr_odd_row  = OA_W'(wr.entry_index[ENTRY_IDX_W-1:1]);

   // Entries i and i+1: the odd one is at row i/2; the even one moves up a
   // row when i is odd.
   assign rd_odd_row  = OA_W'(rd_index >> 1);
   assign rd_even_row = EA_W'(rd_index >> 1) + EA_W'(rd_index[0]);

   always_ff @(posedge clock) begin
      if (wr_en && entry_ok) begin
         if (!wr.entry_index[0]) begin
            case (wr.channel)
               CH_RED:   even_mem[wr_even_row][0] <= wr.value;
               CH_GREEN: even_mem[wr_even_row][1] <= wr.value;
               CH_BLUE:  even_mem[wr_even_row][2] <= wr.value;
               default: begin
               end
            endcase
         end else begin
            case (wr.channel)
               CH_RED:   odd_mem[wr_odd_row][0] <= wr.value;
               CH_GREEN: odd_mem[wr_odd_row][1] <= wr.value;
               CH_BLUE:  odd_mem[wr_odd_row][2] <= wr.value;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         even_rd_ff   <= even_mem[rd_even_row];
         odd_rd_ff    <= odd_mem[rd_odd_row];
         odd_first_ff <= rd_index[0];
      end
   end

   assign lo_words = odd_first_ff ? odd_rd_ff : even_rd_ff;
   assign hi_words = odd_first_ff ? even_rd_ff : odd_rd_ff;

endmodule

>>> rtl/core/bbci_blend.sv
// ----------------------------------------------------------------------------
// bbci_blend
// Three-lane linear interpolation between two table entries, followed by
// the optional raw scale and rounding to the Q16.16 result.
// ----------------------------------------------------------------------------
module bbci_blend (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              valid_in,
   input  logic [bbci_pkg::FRAC_W-1:0]       frac,
   input  bbci_pkg::color_words_type         lo_words,
   input  bbci_pkg::color_words_type         hi_words,
   input  logic                              normalize_enable,
   input  logic [bbci_pkg::RAW_W-1:0]        raw_scale,
   output logic                              rsp_strobe,
   output bbci_pkg::rsp_type                 rsp_data
);
   import bbci_pkg::*;

   localparam int PROD_W   = FRAC_W + WORD_W;
   localparam int SCALED_W = WORD_W + RAW_W + 1;
   localparam logic [PROD_W-1:0]   PROD_HALF   = PROD_W'(32768);
   localparam logic [SCALED_W-1:0] SCALED_HALF = SCALED_W'(32768);

   logic [FRAC_W-1:0] frac_inv;

   logic [NUM_CHANNELS-1:0][PROD_W-1:0]   lo_prod_ff;
   logic [NUM_CHANNELS-1:0][PROD_W-1:0]   hi_prod_ff;
   logic [NUM_CHANNELS-1:0][PROD_W-1:0]   sum_in;
   logic [NUM_CHANNELS-1:0][WORD_W-1:0]   lerp_ff;
   logic [NUM_CHANNELS-1:0][WORD_W-1:0]   lerp_hold_ff;
   logic [NUM_CHANNELS-1:0][SCALED_W-1:0] scaled_ff;
   logic [NUM_CHANNELS-1:0][SCALED_W-1:0] rounded_in;
   logic [NUM_CHANNELS-1:0][COLOR_W-1:0]  color_in;
   logic [NUM_CHANNELS-1:0][COLOR_W-1:0]  color_ff;

   logic prod_valid_ff;
   logic lerp_valid_ff;
   logic scaled_valid_ff;
   logic out_valid_ff;

   assign frac_inv = FRAC_ONE - frac;

   always_comb begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         sum_in[ch]     = lo_prod_ff[ch] + hi_prod_ff[ch] + PROD_HALF;
         rounded_in[ch] = scaled_ff[ch] + SCALED_HALF;
         // The rounded, shifted value has at most 26 bits, so the 32-bit result
         // never reaches its saturation point.
         if (normalize_enable) begin
            color_in[ch] = COLOR_W'(lerp_hold_ff[ch]);
         end else begin
            color_in[ch] = COLOR_W'(rounded_in[ch][SCALED_W-1:16]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         lo_prod_ff[ch]   <= PROD_W'(frac_inv) * PROD_W'(lo_words[ch]);
         hi_prod_ff[ch]   <= PROD_W'(frac) * PROD_W'(hi_words[ch]);
         lerp_ff[ch]      <= sum_in[ch][WORD_W+15:16];
         lerp_hold_ff[ch] <= lerp_ff[ch];
         scaled_ff[ch]    <= SCALED_W'(lerp_ff[ch]) * SCALED_W'(raw_scale);
         color_ff[ch]     <= color_in[ch];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff   <= 1'b0;
         lerp_valid_ff   <= 1'b0;
         scaled_valid_ff <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         prod_valid_ff   <= valid_in;
         lerp_valid_ff   <= prod_valid_ff;
         scaled_valid_ff <= lerp_valid_ff;
         out_valid_ff    <= scaled_valid_ff;
      end
   end

   assign rsp_strobe     = out_valid_ff;
   assign rsp_data.red   = color_ff[0];
   assign rsp_data.green = color_ff[1];
   assign rsp_data.blue  = color_ff[2];

endmodule

>>> rtl/core/blackbody_lut_color_interp.sv
// ----------------------------------------------------------------------------
// blackbody_lut_color_interp
// Temperature to RGB emission color by linear interpolation in a loadable
// table of TABLE_ENTRIES color entries.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                 Payload           Direction
//   request   start / busy              req_data          in
//   result    rsp_strobe                rsp_data          out
//   config    csr_write_enable          csr_index, data   in
//
// One request is taken every cycle; busy stays low. An evaluate request
// shows its result on rsp_strobe after the clamp stage, the position
// multiplier, the table read and the blend and scale multiplier stages.
// A table write request gives no result. Reset clears the pipeline and
// the registers; the table holds no reset value and needs no clearing
// pass. The receiver cannot stall.
//
module blackbody_lut_color_interp #(
   parameter int TABLE_ENTRIES = bbci_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  bbci_pkg::req_type                  req_data,
   output logic                               rsp_strobe,
   output bbci_pkg::rsp_type                  rsp_data,
   input  logic                               csr_write_enable,
   input  logic [bbci_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bbci_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import bbci_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   logic [TEMP_W-1:0]  t_min_ff;
   logic [TEMP_W-1:0]  t_max_ff;
   logic [SCALE_W-1:0] index_scale_ff;
   logic               normalize_ff;
   logic [RAW_W-1:0]   raw_scale_ff;

   logic               req_accept;
   pipe_ctl_type       pos_ctl;
   logic [IDX_W-1:0]   pos_index;
   logic [FRAC_W-1:0]  pos_frac;

   table_wr_type       wr1_ff;
   table_wr_type       wr2_ff;
   logic               table_wr_en;
   logic               table_rd_en;
   color_words_type    lo_words;
   color_words_type    hi_words;

   logic [FRAC_W-1:0]  frac3_ff;
   logic               valid3_ff;

   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_min_ff       <= T_MIN_RESET;
         t_max_ff       <= T_MAX_RESET;
         index_scale_ff <= INDEX_SCALE_RESET;
         normalize_ff   <= NORMALIZE_RESET;
         raw_scale_ff   <= RAW_SCALE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_T_MIN:            t_min_ff       <= csr_write_data[TEMP_W-1:0];
            CSR_T_MAX:            t_max_ff       <= csr_write_data[TEMP_W-1:0];
            CSR_INDEX_SCALE:      index_scale_ff <= csr_write_data[SCALE_W-1:0];
            CSR_NORMALIZE_ENABLE: normalize_ff   <= csr_write_data[0];
            CSR_RAW_SCALE:        raw_scale_ff   <= csr_write_data[RAW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   bbci_position #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_position (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .kind        (req_data.kind),
      .temperature (req_data.temperature),
      .t_min       (t_min_ff),
      .t_max       (t_max_ff),
      .index_scale (index_scale_ff),
      .ctl         (pos_ctl),
      .index       (pos_index),
      .frac        (pos_frac)
   );

   // Table writes travel down the pipeline and reach the table in the same
   // stage where lookups read it, so every lookup sees exactly the writes
   // taken before it and none after it.
   always_ff @(posedge clock) begin
      wr1_ff.entry_index <= req_data.entry_index;
      wr1_ff.channel     <= req_data.channel;
      wr1_ff.value       <= req_data.entry_value;
      wr2_ff             <= wr1_ff;
      frac3_ff           <= pos_frac;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else begin
         valid3_ff <= table_rd_en;
      end
   end

   assign table_wr_en = pos_ctl.valid && pos_ctl.is_write;
   assign table_rd_en = pos_ctl.valid && !pos_ctl.is_write;

   bbci_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock    (clock),
      .wr_en    (table_wr_en),
      .wr       (wr2_ff),
      .rd_en    (table_rd_en),
      .rd_index (pos_index),
      .lo_words (lo_words),
      .hi_words (hi_words)
   );

   bbci_blend u_blend (
      .clock            (clock),
      .reset            (reset),
      .valid_in         (valid3_ff),
      .frac             (frac3_ff),
      .lo_words         (lo_words),
      .hi_words         (hi_words),
      .normalize_enable (normalize_ff),
      .raw_scale        (raw_scale_ff),
      .rsp_strobe       (rsp_strobe),
      .rsp_data         (rsp_data)
   );

   a_eval_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.kind == KIND_EVAL)) |-> ##PIPE_LATENCY rsp_strobe)
      else $error("evaluate request produced no result");

   a_write_gives_none: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.kind == KIND_WRITE)) |-> ##PIPE_LATENCY !rsp_strobe)
      else $error("table write request produced a result");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_accept && (req_data.kind == KIND_EVAL), PIPE_LATENCY))
      else $error("result without a matching evaluate request");

endmodule

>>> dv/blackbody_lut_color_interp_tb.sv
// ----------------------------------------------------------------------------
// blackbody_lut_color_interp_tb
// Self-checking bench for the black-body color lookup. It loads the whole
// color table, runs directed and random evaluate and table write requests
// under several register settings, predicts every color in a scoreboard and
// compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blackbody_lut_color_interp_tb;
   import bbci_pkg::*;

   localparam int TABLE_ENTRIES   = DEFAULT_TABLE_ENTRIES;
   localparam int TABLE_WORDS     = DEFAULT_TABLE_ENTRIES * NUM_CHANNELS;
   localparam int PHASE_REQUESTS  = 144;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam logic [CHAN_W-1:0] CH_NONE = 2'd3;

   class color_scoreboard;
      logic [TEMP_W-1:0]  t_lo       = T_MIN_RESET;
      logic [TEMP_W-1:0]  t_hi       = T_MAX_RESET;
      logic [SCALE_W-1:0] pos_scale  = INDEX_SCALE_RESET;
      logic               unit_scale = NORMALIZE_RESET;
      logic [RAW_W-1:0]   out_gain   = RAW_SCALE_RESET;
      logic [WORD_W-1:0]  color_words [TABLE_WORDS];
      rsp_type            pending_colors [$];
      int errors         = 0;
      int evaluations    = 0;
      int table_writes   = 0;
      int ignored_writes = 0;

      function void note_config(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_T_MIN:            t_lo       = data[TEMP_W-1:0];
            CSR_T_MAX:            t_hi       = data[TEMP_W-1:0];
            CSR_INDEX_SCALE:      pos_scale  = data[SCALE_W-1:0];
            CSR_NORMALIZE_ENABLE: unit_scale = data[0];
            CSR_RAW_SCALE:        out_gain   = data[RAW_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [COLOR_W-1:0] blend_scale(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                                                logic [63:0] frac);
         logic [63:0] v;
         v = ((64'd65536 - frac) * 64'(a) + frac * 64'(b) + 64'd32768) >> 16;
         if (!unit_scale)
            v = (v * 64'(out_gain) + 64'd32768) >> 16;
         if (v > 64'hFFFF_FFFF)
            v = 64'hFFFF_FFFF;
         return v[COLOR_W-1:0];
      endfunction

      function rsp_type interpolate_color(logic [TEMP_W-1:0] temp);
         logic [TEMP_W-1:0] t;
         logic [TEMP_W-1:0] offset;
         logic [63:0]       pos;
         logic [63:0]       idx;
         logic [63:0]       frac;
         int                lo_word;
         rsp_type           c;
         t = temp;
         if (t < t_lo)
            t = t_lo;
         else if (t > t_hi)
            t = t_hi;
         // With an inverted range the clamped value can sit below t_min.
         offset = (t >= t_lo) ? t - t_lo : '0;
         pos = 64'(offset) * 64'(pos_scale);
         idx = pos >> 32;
         if (idx > 64'(TABLE_ENTRIES - 2))
            idx = 64'(TABLE_ENTRIES - 2);
         // Past the last segment the weight stops at one, so no extrapolation.
         frac = (pos >> 16) - (idx << 16);
         if (frac > 64'd65536)
            frac = 64'd65536;
         lo_word = int'(idx) * NUM_CHANNELS;
         c.red   = blend_scale(color_words[lo_word + CH_RED],
                               color_words[lo_word + NUM_CHANNELS + CH_RED], frac);
         c.green = blend_scale(color_words[lo_word + CH_GREEN],
                               color_words[lo_word + NUM_CHANNELS + CH_GREEN], frac);
         c.blue  = blend_scale(color_words[lo_word + CH_BLUE],
                               color_words[lo_word + NUM_CHANNELS + CH_BLUE], frac);
         return c;
      endfunction

      function void note_request(req_type r);
         if (r.kind == KIND_WRITE) begin
            if (r.channel < NUM_CHANNELS && r.entry_index < TABLE_ENTRIES) begin
               color_words[int'(r.entry_index) * NUM_CHANNELS + r.channel] = r.entry_value;
               table_writes++;
            end else begin
               ignored_writes++;
            end
         end else begin
            pending_colors.push_back(interpolate_color(r.temperature));
         end
      endfunction

      function void compare_field(string name, logic [COLOR_W-1:0] want,
                                  logic [COLOR_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_colors.size() == 0) begin
            errors++;
            $display("%0t: result %h with no request waiting", $time, got);
            return;
         end
         want = pending_colors.pop_front();
         evaluations++;
         compare_field("red", want.red, got.red);
         compare_field("green", want.green, got.green);
         compare_field("blue", want.blue, got.blue);
      endfunction
   endclass

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  start            = 1'b0;
   logic                  busy;
   req_type               req_data         = '0;
   logic                  rsp_strobe;
   rsp_type               rsp_data;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_write_data   = '0;

   color_scoreboard board = new;
   req_type         request_queue [$];
   bit              idling_on = 1'b1;
   int              settings_used = 0;
   int              idle_cycles = 0;

   blackbody_lut_color_interp #(.TABLE_ENTRIES(TABLE_ENTRIES)) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         board.check_result(rsp_data);
   end

   // Counts cycles in which neither a request nor a result moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     board.pending_colors.size());
            $display("blackbody_lut_color_interp_tb failed");
            $finish;
         end
      end
   end

   function automatic req_type eval_req(logic [TEMP_W-1:0] t);
      req_type r;
      r = '0;
      r.kind = KIND_EVAL;
      r.temperature = t;
      return r;
   endfunction

   function automatic req_type write_req(int entry, logic [CHAN_W-1:0] ch,
                                         logic [WORD_W-1:0] value);
      req_type r;
      r = '0;
      r.kind = KIND_WRITE;
      r.entry_index = entry[ENTRY_IDX_W-1:0];
      r.channel = ch;
      r.entry_value = value;
      return r;
   endfunction

   // Reciprocal step that spreads [lo, hi] over the whole table.
   function automatic logic [SCALE_W-1:0] span_scale(logic [TEMP_W-1:0] lo,
                                                     logic [TEMP_W-1:0] hi);
      logic [63:0] s;
      if (hi <= lo)
         return '0;
      s = (64'(TABLE_ENTRIES - 1) << 32) / 64'(hi - lo);
      return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[SCALE_W-1:0];
   endfunction

   task automatic send_request(input req_type r);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      board.note_request(r);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (board.pending_colors.size() != 0)
         @(posedge clock);
      // Table writes leave no result, so let the pipeline empty out as well.
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic issue_requests(input bit drain_mid);
      int  n;
      bit  gap;
      bit  pause_here;
      n = request_queue.size();
      for (int k = 0; k < n; k++) begin
         send_request(request_queue[k]);
         gap = idling_on && ($urandom_range(0, 99) < 4);
         pause_here = drain_mid && (k == n / 2);
         if (gap) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         if (pause_here)
            wait_drained();
      end
      request_queue.delete();
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      board.note_config(idx, data);
   endtask

   task automatic apply_settings(input logic [TEMP_W-1:0] lo, input logic [TEMP_W-1:0] hi,
                                 input logic [SCALE_W-1:0] scale, input logic unit,
                                 input logic [RAW_W-1:0] gain);
      wait_drained();
      write_csr(CSR_T_MIN, 32'(lo));
      write_csr(CSR_T_MAX, 32'(hi));
      write_csr(CSR_INDEX_SCALE, scale);
      write_csr(CSR_NORMALIZE_ENABLE, 32'(unit));
      write_csr(CSR_RAW_SCALE, 32'(gain));
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return WORD_W'($urandom_range(0, 18'h3FFFF));
      endcase
   endfunction

   function automatic logic [TEMP_W-1:0] random_temperature();
      case ($urandom_range(0, 9))
         0: return TEMP_W'($urandom_range(0, 20'hFFFFF));
         1: begin
            case ($urandom_range(0, 5))
               0:       return '0;
               1:       return '1;
               2:       return board.t_lo;
               3:       return board.t_hi;
               4:       return board.t_lo - 1'b1;
               default: return board.t_hi + 1'b1;
            endcase
         end
         default: begin
            if (board.t_lo <= board.t_hi)
               return TEMP_W'($urandom_range(board.t_lo, board.t_hi));
            return TEMP_W'($urandom_range(0, 20'hFFFFF));
         end
      endcase
   endfunction

   // Mostly evaluations inside the active range; unused fields carry junk.
   task automatic queue_random(input int n);
      req_type r;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 99) < 72) begin
            r = eval_req(random_temperature());
            r.entry_index = ENTRY_IDX_W'($urandom_range(0, 63));
            r.channel = CHAN_W'($urandom_range(0, 3));
            r.entry_value = WORD_W'($urandom_range(0, 18'h3FFFF));
         end else begin
            r = write_req(int'($urandom_range(0, TABLE_ENTRIES - 1)),
                          ($urandom_range(0, 11) == 0) ? CH_NONE
                                                       : CHAN_W'($urandom_range(0, 2)),
                          random_word());
            r.temperature = TEMP_W'($urandom_range(0, 20'hFFFFF));
         end
         request_queue.push_back(r);
      end
   endtask

   task automatic random_phase();
      logic [TEMP_W-1:0]  lo;
      logic [TEMP_W-1:0]  hi;
      logic [SCALE_W-1:0] scale;
      lo = TEMP_W'($urandom_range(0, 20'hF0000));
      hi = TEMP_W'($urandom_range(lo + 64, 20'hFFFFF));
      scale = span_scale(lo, hi);
      case ($urandom_range(0, 9))
         7:       scale = scale + $urandom_range(1, 5000);
         8:       scale = $urandom;
         9:       scale = scale >> 1;
         default: ;
      endcase
      apply_settings(lo, hi, scale, 1'($urandom_range(0, 1)),
                     RAW_W'($urandom_range(0, 24'hFFFFFF)));
      queue_random(PHASE_REQUESTS);
      issue_requests(1'b0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Every table word is written before any evaluation reads it.
      for (int e = 0; e < TABLE_ENTRIES; e++) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (e == 0)
               request_queue.push_back(write_req(e, CHAN_W'(c), '1));
            else if (e == 1)
               request_queue.push_back(write_req(e, CHAN_W'(c), '0));
            else
               request_queue.push_back(write_req(e, CHAN_W'(c), random_word()));
         end
      end
      issue_requests(1'b0);

      // Defaults: clamp edges, an ignored write and writes seen by the next read.
      request_queue.push_back(eval_req('0));
      request_queue.push_back(eval_req('1));
      request_queue.push_back(eval_req(20'd16000));
      request_queue.push_back(eval_req(20'd15999));
      request_queue.push_back(eval_req(20'd16100));
      request_queue.push_back(eval_req(20'd640000));
      request_queue.push_back(eval_req(20'd640001));
      request_queue.push_back(eval_req(20'd328000));
      request_queue.push_back(write_req(5, CH_NONE, '1));
      request_queue.push_back(eval_req(20'd70480));
      request_queue.push_back(write_req(5, CH_RED, '0));
      request_queue.push_back(eval_req(20'd70480));
      request_queue.push_back(write_req(TABLE_ENTRIES - 1, CH_BLUE, '1));
      request_queue.push_back(eval_req(20'd640000));
      issue_requests(1'b0);
      queue_random(PHASE_REQUESTS);
      issue_requests(1'b1);

      // Full temperature range with the largest raw scale.
      apply_settings('0, '1, span_scale('0, '1), 1'b0, '1);
      request_queue.push_back(eval_req('0));
      request_queue.push_back(eval_req('1));
      request_queue.push_back(eval_req(20'h7FFFF));
      issue_requests(1'b0);
      queue_random(PHASE_REQUESTS);
      issue_requests(1'b1);

      // Inverted range, largest step and a zero raw scale.
      apply_settings('1, '0, '1, 1'b0, '0);
      request_queue.push_back(eval_req('0));
      request_queue.push_back(eval_req('1));
      request_queue.push_back(eval_req(20'd12345));
      issue_requests(1'b0);
      queue_random(PHASE_REQUESTS);
      issue_requests(1'b0);

      // Degenerate range with no step at all.
      apply_settings('0, '0, '0, 1'b1, 24'd1);
      queue_random(PHASE_REQUESTS);
      issue_requests(1'b0);

      // Step far too large for the range, so the index is capped.
      apply_settings(20'd1000, 20'd2000, '1, 1'b1, RAW_SCALE_RESET);
      queue_random(PHASE_REQUESTS);
      issue_requests(1'b0);

      for (int p = 0; p < 5; p++) begin
         idling_on = (p != 2);
         random_phase();
      end

      wait_drained();
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      board.errors += board.pending_colors.size();
      $display("Checked %0d colors across %0d register settings after reset defaults.",
               board.evaluations, settings_used);
      $display("Table writes: %0d taken, %0d ignored for an invalid channel.",
               board.table_writes, board.ignored_writes);
      if (board.errors == 0)
         $display("blackbody_lut_color_interp_tb passed");
      else
         $display("blackbody_lut_color_interp_tb failed");
      $finish;
   end

endmodule
